// ===== rtl/mp2_pkg.sv =====
// Shared constants and types for the 2x2 max pooling stream core.
// No dependencies; used by max_pool_2x2_stream_core.
package mp2_pkg;

    localparam int DEFAULT_MAX_SIDE    = 512;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int CFG_W    = 10;
    localparam int STRIDE_W = 2;
    localparam int COORD_W  = 9;
    localparam int RES_N    = 4;

    localparam logic [CFG_W-1:0]    PLANE_SIDE_RESET  = CFG_W'(416);
    localparam logic [STRIDE_W-1:0] POOL_STRIDE_RESET = STRIDE_W'(2);
    localparam logic [STRIDE_W-1:0] STRIDE_ONE        = STRIDE_W'(1);

    typedef enum logic
    {
        REG_PLANE_SIDE  = 1'b0,
        REG_POOL_STRIDE = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               done;
    } coord_t;

endpackage

// ===== rtl/max_pool_2x2_stream_core.sv =====
// 2x2 max pooling over a raster stream of square planes, stride 1 or 2.
// Depends on mp2_pkg for constants, register indexes and the coordinate type.
//
// The core takes one sample per clock while in_stall is low. A sample whose window set yields k
// results (k up to 4, only at the right column and bottom row with stride 1) holds the input
// until its last result has moved, since the output register moves one result per cycle while
// out_stall is low. The row above lives in a single-port line buffer of MAX_SIDE entries; each
// accepted sample reads the entry for its column and overwrites it in the same cycle, and the
// read data, registered in above_reg, feeds the window stage in the next cycle. An accepted
// sample is registered in the window stage, and its results are then registered in the output
// register. The line buffer needs no clearing after reset.
module max_pool_2x2_stream_core
#(
    parameter int MAX_SIDE    = mp2_pkg::DEFAULT_MAX_SIDE,
    parameter int SAMPLE_BITS = mp2_pkg::DEFAULT_SAMPLE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [mp2_pkg::CFG_W-1:0]         cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     pooled,
    output logic [mp2_pkg::COORD_W-1:0]       out_col,
    output logic [mp2_pkg::COORD_W-1:0]       out_row,
    output logic                              plane_done
);

    localparam int CNT_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > mp2_pkg::CFG_W) ? SIDE_W : mp2_pkg::CFG_W;
    localparam int RES_N  = mp2_pkg::RES_N;
    localparam int CW     = mp2_pkg::COORD_W;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    function automatic smp_t smax(input smp_t a, input smp_t b);
        return (a > b) ? a : b;
    endfunction

    // configuration
    logic [mp2_pkg::CFG_W-1:0]    plane_side_reg;
    logic [mp2_pkg::STRIDE_W-1:0] pool_stride_reg;
    logic [SIDE_W-1:0]            side;
    logic [SIDE_W-1:0]            side_even;
    logic [CMP_W-1:0]             side_raw;
    logic                         stride1;

    // position counters
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_a, row_a;
    logic [SIDE_W-1:0] col_aw, row_aw, col_inc, row_inc;
    logic              wrap;
    logic              accept;

    // line buffer
    smp_t line_mem [MAX_SIDE];
    smp_t above_reg;

    // window stage
    logic             b_valid_reg, b_valid_next;
    logic [RES_N-1:0] b_mask_reg, b_mask_next, mask_a;
    logic             b_done_reg, done_a;
    logic             b_stride1_reg;
    logic [CNT_W-1:0] b_col_reg, b_row_reg;
    smp_t             b_sample_reg;
    smp_t             left_reg, above_left_reg;
    logic             b_retire;
    logic             out_load_ok;
    logic             move;

    smp_t                 res_val [RES_N];
    mp2_pkg::coord_t      res_pos [RES_N];
    logic [RES_N-1:0]     sel_onehot;
    logic [RES_N-1:0]     mask_rest;
    smp_t                 sel_val;
    mp2_pkg::coord_t      sel_pos;
    smp_t                 m4;

    // output register
    logic            out_valid_reg, out_valid_next;
    smp_t            pooled_reg;
    mp2_pkg::coord_t pos_reg;

    always_comb
    begin
        side_raw = CMP_W'(plane_side_reg);
        if (side_raw < CMP_W'(2))
            side = SIDE_W'(2);
        else if (side_raw > CMP_W'(MAX_SIDE))
            side = SIDE_W'(MAX_SIDE);
        else
            side = SIDE_W'(side_raw);
        side_even = {side[SIDE_W-1:1], 1'b0};
        stride1   = (pool_stride_reg == mp2_pkg::STRIDE_ONE);
    end

    assign accept = in_valid && !in_stall;

    // input stage: position, next position and result mask
    always_comb
    begin
        wrap   = (SIDE_W'(col_reg) >= side) || (SIDE_W'(row_reg) >= side);
        col_a  = wrap ? '0 : col_reg;
        row_a  = wrap ? '0 : row_reg;
        col_aw = SIDE_W'(col_a);
        row_aw = SIDE_W'(row_a);

        col_inc = col_aw + SIDE_W'(1);
        row_inc = row_aw;
        if (col_inc >= side)
        begin
            col_inc = '0;
            row_inc = row_aw + SIDE_W'(1);
            if (row_inc >= side)
                row_inc = '0;
        end

        mask_a = '0;
        done_a = 1'b0;
        if (stride1)
        begin
            mask_a[0] = (row_aw != '0) && (col_aw != '0);
            mask_a[1] = (row_aw != '0) && (col_aw == side - SIDE_W'(1));
            mask_a[2] = (row_aw == side - SIDE_W'(1)) && (col_aw != '0);
            mask_a[3] = (row_aw == side - SIDE_W'(1)) && (col_aw == side - SIDE_W'(1));
        end
        else
        begin
            mask_a[0] = row_a[0] && col_a[0] && (row_aw < side_even) && (col_aw < side_even);
            done_a    = (row_aw == side_even - SIDE_W'(1))
                        && (col_aw == side_even - SIDE_W'(1));
        end

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            col_next = CNT_W'(col_inc);
            row_next = CNT_W'(row_inc);
        end
    end

    // read old entry, write the new sample back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg      <= line_mem[col_a];
            line_mem[col_a] <= sample;
        end
    end

    // window results
    always_comb
    begin
        m4 = smax(smax(above_left_reg, above_reg), smax(left_reg, b_sample_reg));

        res_val[0] = m4;
        res_val[1] = smax(above_reg, b_sample_reg);
        res_val[2] = smax(left_reg, b_sample_reg);
        res_val[3] = b_sample_reg;

        if (b_stride1_reg)
        begin
            res_pos[0] = '{col: CW'(b_col_reg - CNT_W'(1)),
                           row: CW'(b_row_reg - CNT_W'(1)), done: 1'b0};
        end
        else
        begin
            res_pos[0] = '{col: CW'(b_col_reg >> 1), row: CW'(b_row_reg >> 1),
                           done: b_done_reg};
        end
        res_pos[1] = '{col: CW'(b_col_reg), row: CW'(b_row_reg - CNT_W'(1)), done: 1'b0};
        res_pos[2] = '{col: CW'(b_col_reg - CNT_W'(1)), row: CW'(b_row_reg), done: 1'b0};
        res_pos[3] = '{col: CW'(b_col_reg), row: CW'(b_row_reg), done: 1'b1};

        sel_onehot = b_mask_reg & (~b_mask_reg + RES_N'(1));
        mask_rest  = b_mask_reg & ~sel_onehot;

        sel_val = res_val[0];
        sel_pos = res_pos[0];
        for (int i = 0; i < RES_N; i++)
        begin
            if (sel_onehot[i])
            begin
                sel_val = res_val[i];
                sel_pos = res_pos[i];
            end
        end
    end

    // emit control
    always_comb
    begin
        out_load_ok = !out_valid_reg || !out_stall;
        move        = b_valid_reg && (b_mask_reg != '0) && out_load_ok;
        b_retire    = b_valid_reg && ((b_mask_reg == '0) || (move && (mask_rest == '0)));
        in_stall    = b_valid_reg && !b_retire;

        b_valid_next = b_valid_reg;
        b_mask_next  = b_mask_reg;
        if (accept)
        begin
            b_valid_next = 1'b1;
            b_mask_next  = mask_a;
        end
        else if (b_retire)
        begin
            b_valid_next = 1'b0;
            b_mask_next  = '0;
        end
        else if (move)
        begin
            b_mask_next = mask_rest;
        end

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_side_reg  <= mp2_pkg::PLANE_SIDE_RESET;
            pool_stride_reg <= mp2_pkg::POOL_STRIDE_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            b_valid_reg     <= 1'b0;
            b_mask_reg      <= '0;
            out_valid_reg   <= 1'b0;
            left_reg        <= '0;
            above_left_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mp2_pkg::REG_PLANE_SIDE:  plane_side_reg  <= cfg_data;
                    mp2_pkg::REG_POOL_STRIDE: pool_stride_reg <= cfg_data[mp2_pkg::STRIDE_W-1:0];
                    default:                  plane_side_reg  <= plane_side_reg;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            b_valid_reg   <= b_valid_next;
            b_mask_reg    <= b_mask_next;
            out_valid_reg <= out_valid_next;
            // advance neighbors as the window leaves
            if (b_retire)
            begin
                left_reg       <= b_sample_reg;
                above_left_reg <= above_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sample_reg  <= sample;
            b_col_reg     <= col_a;
            b_row_reg     <= row_a;
            b_done_reg    <= done_a;
            b_stride1_reg <= stride1;
        end
        if (move)
        begin
            pooled_reg <= sel_val;
            pos_reg    <= sel_pos;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pooled     = pooled_reg;
    assign out_col    = pos_reg.col;
    assign out_row    = pos_reg.row;
    assign plane_done = pos_reg.done;

    a_pos_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (SIDE_W'(col_reg) < side) && (SIDE_W'(row_reg) < side))
        else $error("position counter outside plane");

    a_mask_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !b_valid_reg |-> (b_mask_reg == '0))
        else $error("pending results without a window");

    a_stride2_single: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_stride1_reg) |-> (b_mask_reg[RES_N-1:1] == '0))
        else $error("stride 2 window with more than one result");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("transfer lost before the window stage");

    a_move_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("result moved without output valid");

endmodule
